### src/evs_pkg.sv
// Shared types and constants for the energy VAD chunk segmenter.
// Used by every module under src; depends on nothing else.
package evs_pkg;

  localparam int unsigned MAX_FRAME = 4096;
  localparam int unsigned MAX_CHUNK = 1048576;

  localparam int unsigned FLEN_W   = 13;
  localparam int unsigned THR_W    = 43;
  localparam int unsigned QUIET_W  = 10;
  localparam int unsigned CHUNK_W  = 21;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SQ_W     = 31;
  localparam int unsigned ENERGY_W = 43;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 64;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_FLUSH  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    CAUSE_SILENCE = 2'd0,
    CAUSE_CAP     = 2'd1,
    CAUSE_FLUSH   = 2'd2
  } cause_e;

  typedef enum logic [1:0] {
    REG_FRAME_LENGTH = 2'd0,
    REG_ENERGY_THR   = 2'd1,
    REG_QUIET_FRAMES = 2'd2,
    REG_MAX_CHUNK    = 2'd3
  } reg_e;

  typedef struct packed {
    logic                       req_type;
    logic signed [SAMPLE_W-1:0] sample;
  } req_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] chunk_length;
    logic               has_speech;
    logic [1:0]         end_cause;
  } res_t;

  // One classified beat between front and back.
  typedef struct packed {
    logic            flush;
    logic [SQ_W-1:0] sq;
  } op_t;

  typedef struct packed {
    logic [FLEN_W-1:0]  frame_length;
    logic [THR_W-1:0]   energy_threshold;
    logic [QUIET_W-1:0] quiet_frames_to_cut;
    logic [CHUNK_W-1:0] max_chunk_length;
  } cfg_t;

endpackage

### src/evs_front.sv
// Front stage: accept a request beat, classify it and square the sample.
// Depends on evs_pkg.
module evs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  evs_pkg::req_t in_req_i,
  output logic          op_valid_o,
  input  logic          op_ready_i,
  output evs_pkg::op_t  op_o
);

  logic         valid_q, valid_d;
  evs_pkg::op_t op_q, op_d;
  logic signed [2*evs_pkg::SAMPLE_W-1:0] prod;

  assign in_ready_o = !valid_q || op_ready_i;
  assign prod = (2*evs_pkg::SAMPLE_W)'(in_req_i.sample) *
                (2*evs_pkg::SAMPLE_W)'(in_req_i.sample);

  always_comb begin
    valid_d = valid_q;
    op_d    = op_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      op_d.flush = (in_req_i.req_type == evs_pkg::REQ_FLUSH);
      // Drop the sample of a flush so the back end sees a clean zero.
      op_d.sq = op_d.flush ? '0 : prod[evs_pkg::SQ_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign op_valid_o = valid_q;
  assign op_o       = op_q;

endmodule

### src/evs_queue.sv
// Short queue of classified beats between front and back.
// Depends on evs_pkg.
module evs_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  evs_pkg::op_t push_op_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output evs_pkg::op_t pop_op_o
);

  evs_pkg::op_t                  mem_q [evs_pkg::QDEPTH];
  logic [evs_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [evs_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [evs_pkg::QPTR_W:0]      count_q, count_d;
  logic                          push, pop;

  assign push_ready_o = (count_q != (evs_pkg::QPTR_W+1)'(evs_pkg::QDEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_op_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

### src/evs_back.sv
// Back end: frame energy, speech tracking, chunk cuts and the result register.
// Depends on evs_pkg.
module evs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  evs_pkg::cfg_t cfg_i,
  input  logic          op_valid_i,
  output logic          op_ready_o,
  input  evs_pkg::op_t  op_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output evs_pkg::res_t out_res_o
);

  logic [evs_pkg::ENERGY_W-1:0] energy_q, energy_d;
  logic [evs_pkg::FLEN_W-1:0]   fill_q, fill_d;
  logic [evs_pkg::CHUNK_W-1:0]  count_q, count_d;
  logic [evs_pkg::QUIET_W-1:0]  quiet_q, quiet_d;
  logic                         speaking_q, speaking_d;
  logic                         seen_q, seen_d;
  logic                         out_valid_q, out_valid_d;
  evs_pkg::res_t                res_q, res_d;

  logic                         pop;
  logic [evs_pkg::FLEN_W-1:0]   flen;
  logic [evs_pkg::CHUNK_W-1:0]  cap;
  logic [evs_pkg::CHUNK_W-1:0]  count_inc;
  logic [evs_pkg::FLEN_W-1:0]   fill_inc;
  logic [evs_pkg::ENERGY_W-1:0] energy_sum;
  logic                         frame_done, is_speech, by_silence, by_cap;
  logic                         speaking_f, seen_f;
  logic [evs_pkg::QUIET_W-1:0]  quiet_f;
  logic                         cut;
  logic [1:0]                   cause;

  assign op_ready_o = !out_valid_q || out_ready_i;
  assign pop = op_valid_i && op_ready_o;

  always_comb begin
    if (cfg_i.frame_length == '0) begin
      flen = evs_pkg::FLEN_W'(1);
    end else if (cfg_i.frame_length > evs_pkg::FLEN_W'(evs_pkg::MAX_FRAME)) begin
      flen = evs_pkg::FLEN_W'(evs_pkg::MAX_FRAME);
    end else begin
      flen = cfg_i.frame_length;
    end
    if (cfg_i.max_chunk_length > evs_pkg::CHUNK_W'(evs_pkg::MAX_CHUNK)) begin
      cap = evs_pkg::CHUNK_W'(evs_pkg::MAX_CHUNK);
    end else begin
      cap = cfg_i.max_chunk_length;
    end
  end

  always_comb begin
    count_inc  = count_q + 1'b1;
    fill_inc   = fill_q + 1'b1;
    energy_sum = energy_q + evs_pkg::ENERGY_W'(op_i.sq);
    frame_done = (fill_inc >= flen);
    is_speech  = (energy_sum >= cfg_i.energy_threshold);

    speaking_f = speaking_q;
    seen_f     = seen_q;
    quiet_f    = quiet_q;
    if (is_speech) begin
      speaking_f = 1'b1;
      seen_f     = 1'b1;
      quiet_f    = '0;
    end else if (speaking_q && quiet_q != '1) begin
      quiet_f = quiet_q + 1'b1;
    end
    by_silence = speaking_f && (quiet_f >= cfg_i.quiet_frames_to_cut);
    by_cap     = (count_inc >= cap);

    energy_d    = energy_q;
    fill_d      = fill_q;
    count_d     = count_q;
    quiet_d     = quiet_q;
    speaking_d  = speaking_q;
    seen_d      = seen_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cut         = 1'b0;
    cause       = evs_pkg::CAUSE_FLUSH;

    if (pop) begin
      if (op_i.flush) begin
        cut   = (count_q != '0);
        cause = evs_pkg::CAUSE_FLUSH;
        // An empty flush only clears state.
        if (!cut) begin
          energy_d   = '0;
          fill_d     = '0;
          count_d    = '0;
          quiet_d    = '0;
          speaking_d = 1'b0;
          seen_d     = 1'b0;
        end
      end else begin
        count_d = count_inc;
        if (frame_done) begin
          energy_d   = '0;
          fill_d     = '0;
          quiet_d    = quiet_f;
          speaking_d = speaking_f;
          seen_d     = seen_f;
          if (by_silence) begin
            cut   = 1'b1;
            cause = evs_pkg::CAUSE_SILENCE;
          end else if (by_cap) begin
            cut   = 1'b1;
            cause = evs_pkg::CAUSE_CAP;
          end
        end else begin
          energy_d = energy_sum;
          fill_d   = fill_inc;
          if (by_cap) begin
            cut   = 1'b1;
            cause = evs_pkg::CAUSE_CAP;
          end
        end
      end

      out_valid_d = cut;
      if (cut) begin
        res_d.chunk_length = count_d;
        res_d.has_speech   = seen_d;
        res_d.end_cause    = cause;
        energy_d   = '0;
        fill_d     = '0;
        count_d    = '0;
        quiet_d    = '0;
        speaking_d = 1'b0;
        seen_d     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q    <= '0;
      fill_q      <= '0;
      count_q     <= '0;
      quiet_q     <= '0;
      speaking_q  <= 1'b0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      energy_q    <= energy_d;
      fill_q      <= fill_d;
      count_q     <= count_d;
      quiet_q     <= quiet_d;
      speaking_q  <= speaking_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

### src/energy_vad_chunk_segmenter.sv
// Top level of the energy VAD chunk segmenter: register file, front, queue, back.
// Depends on evs_pkg, evs_front, evs_queue and evs_back.
//
//   channel   direction  handshake                beat
//   in        sink       in_valid_i/in_ready_o    evs_pkg::req_t {req_type, sample}
//   out       source     out_valid_o/out_ready_i  evs_pkg::res_t {length, speech, cause}
//   apb       slave      psel/penable/pready      64-bit registers at byte 8*index
//
// Throughput is one beat per cycle in steady state while out is not stalled; the back
// end's combinational energy add and threshold compare set that figure.
// An accepted beat is registered first in the square register, then in a queue entry,
// and the result of a beat that cuts a chunk is then loaded into the result register.
// Reset clears all control and chunk state at once; no clearing pass is needed.
// A stall on out backs up into the four-entry queue and then the square stage;
// in_ready_o drops only once both are full.
module energy_vad_chunk_segmenter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  evs_pkg::req_t                      in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output evs_pkg::res_t                      out_res_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [evs_pkg::APB_AW-1:0]         paddr,
  input  logic [evs_pkg::APB_DW-1:0]         pwdata,
  output logic [evs_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  evs_pkg::cfg_t cfg_q, cfg_d;
  evs_pkg::reg_e reg_sel;
  logic          wr_en;

  logic          f_valid, f_ready;
  evs_pkg::op_t  f_op;
  logic          b_valid, b_ready;
  evs_pkg::op_t  b_op;

  // Register file: one 64-bit slot per register, index in paddr[4:3].
  assign pready  = 1'b1;
  assign reg_sel = evs_pkg::reg_e'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        evs_pkg::REG_FRAME_LENGTH:
          cfg_d.frame_length = pwdata[evs_pkg::FLEN_W-1:0];
        evs_pkg::REG_ENERGY_THR:
          cfg_d.energy_threshold = pwdata[evs_pkg::THR_W-1:0];
        evs_pkg::REG_QUIET_FRAMES:
          cfg_d.quiet_frames_to_cut = pwdata[evs_pkg::QUIET_W-1:0];
        evs_pkg::REG_MAX_CHUNK:
          cfg_d.max_chunk_length = pwdata[evs_pkg::CHUNK_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      evs_pkg::REG_FRAME_LENGTH:
        prdata = evs_pkg::APB_DW'(cfg_q.frame_length);
      evs_pkg::REG_ENERGY_THR:
        prdata = evs_pkg::APB_DW'(cfg_q.energy_threshold);
      evs_pkg::REG_QUIET_FRAMES:
        prdata = evs_pkg::APB_DW'(cfg_q.quiet_frames_to_cut);
      evs_pkg::REG_MAX_CHUNK:
        prdata = evs_pkg::APB_DW'(cfg_q.max_chunk_length);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_length        <= evs_pkg::FLEN_W'(480);
      cfg_q.energy_threshold    <= '0;
      cfg_q.quiet_frames_to_cut <= evs_pkg::QUIET_W'(25);
      cfg_q.max_chunk_length    <= evs_pkg::CHUNK_W'(480000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept and square each beat.
  evs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .op_valid_o (f_valid),
    .op_ready_i (f_ready),
    .op_o       (f_op)
  );

  // Queue: decouple front from back so each can stall on its own.
  evs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_op_i    (f_op),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_op_o     (b_op)
  );

  // Back: frame energy, speech tracking and chunk cuts.
  evs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .op_valid_i  (b_valid),
    .op_ready_o  (b_ready),
    .op_i        (b_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o)
  );

  // A cut chunk always holds at least one sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_res_o.chunk_length != '0)
    else $error("empty chunk reported");

  // Silence after speech implies the chunk held speech.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_res_o.end_cause == evs_pkg::CAUSE_SILENCE)
      |-> out_res_o.has_speech)
    else $error("silence cut without speech");

  // No chunk runs past MAX_CHUNK, the limit the cap is clamped to.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_res_o.chunk_length <= evs_pkg::CHUNK_W'(evs_pkg::MAX_CHUNK))
    else $error("chunk exceeds cap");

  // Only defined cause codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_res_o.end_cause == evs_pkg::CAUSE_SILENCE ||
                     out_res_o.end_cause == evs_pkg::CAUSE_CAP ||
                     out_res_o.end_cause == evs_pkg::CAUSE_FLUSH))
    else $error("bad end cause");

endmodule
